// File: hdl/dop_pkg.sv
// ---------------------------------------------------------------------------
// dop_pkg
// Shared types and option codes for the DHCP options parser.
// ---------------------------------------------------------------------------
`default_nettype none

package dop_pkg;

	localparam logic [7:0] OPT_PAD    = 8'd0;
	localparam logic [7:0] OPT_MASK   = 8'd1;
	localparam logic [7:0] OPT_ROUTER = 8'd3;
	localparam logic [7:0] OPT_DNS    = 8'd6;
	localparam logic [7:0] OPT_LEASE  = 8'd51;
	localparam logic [7:0] OPT_TYPE   = 8'd53;
	localparam logic [7:0] OPT_SERVER = 8'd54;
	localparam logic [7:0] OPT_END    = 8'd255;

	localparam int FLAG_MASK   = 0;
	localparam int FLAG_ROUTER = 1;
	localparam int FLAG_DNS    = 2;
	localparam int FLAG_SERVER = 3;
	localparam int FLAG_TYPE   = 4;
	localparam int FLAG_LEASE  = 5;

	localparam int OUT_TDATA_W = 176;

	typedef enum logic [1:0] {
		PH_CODE,
		PH_LEN,
		PH_VALUE
	} phase_t;

	typedef struct packed {
		logic        end_seen;
		logic [5:0]  found_flags;
		logic [31:0] lease_seconds;
		logic [7:0]  message_type;
		logic [31:0] server_id;
		logic [31:0] dns_addr;
		logic [31:0] gateway_addr;
		logic [31:0] subnet_mask;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/dop_parser.sv
// ---------------------------------------------------------------------------
// dop_parser
// Option record walker: tracks code/length/value phase and collects values.
// ---------------------------------------------------------------------------
`default_nettype none

module dop_parser
	import dop_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            emit,
	output result_t         result
);

	phase_t      phase_q, phase_n;
	logic [7:0]  code_q, code_n;
	logic [7:0]  left_q, left_n;
	logic [2:0]  cnt_q, cnt_n;
	logic [31:0] shift_q, shift_n;
	logic [31:0] mask_q, mask_n;
	logic [31:0] router_q, router_n;
	logic [31:0] dns_q, dns_n;
	logic [31:0] server_q, server_n;
	logic [7:0]  type_q, type_n;
	logic [31:0] lease_q, lease_n;
	logic [5:0]  found_q, found_n;
	logic        done_q, done_n;
	logic        end_hit;

	// next state
	always_comb begin
		phase_n  = phase_q;
		code_n   = code_q;
		left_n   = left_q;
		cnt_n    = cnt_q;
		shift_n  = shift_q;
		mask_n   = mask_q;
		router_n = router_q;
		dns_n    = dns_q;
		server_n = server_q;
		type_n   = type_q;
		lease_n  = lease_q;
		found_n  = found_q;
		done_n   = done_q;
		end_hit  = 1'b0;
		if (step) begin
			if (done_q) begin
				if (last_byte) begin
					done_n = 1'b0;
				end
			end else begin
				case (phase_q)
					PH_CODE: begin
						if (data_byte == OPT_END) begin
							end_hit = 1'b1;
							done_n  = ~last_byte;
						end else if (data_byte != OPT_PAD) begin
							code_n  = data_byte;
							phase_n = PH_LEN;
						end
					end
					PH_LEN: begin
						left_n  = data_byte;
						cnt_n   = 3'd0;
						shift_n = 32'd0;
						phase_n = (data_byte == 8'd0) ? PH_CODE : PH_VALUE;
					end
					PH_VALUE: begin
						if (cnt_q < 3'd4) begin
							shift_n = {shift_q[23:0], data_byte};
							cnt_n   = cnt_q + 3'd1;
							if (cnt_q == 3'd0 && code_q == OPT_TYPE && !found_q[FLAG_TYPE]) begin
								type_n             = data_byte;
								found_n[FLAG_TYPE] = 1'b1;
							end
							if (cnt_q == 3'd3) begin
								case (code_q)
									OPT_MASK: begin
										mask_n             = shift_n;
										found_n[FLAG_MASK] = 1'b1;
									end
									OPT_ROUTER: begin
										router_n             = shift_n;
										found_n[FLAG_ROUTER] = 1'b1;
									end
									OPT_DNS: begin
										dns_n             = shift_n;
										found_n[FLAG_DNS] = 1'b1;
									end
									OPT_SERVER: begin
										server_n             = shift_n;
										found_n[FLAG_SERVER] = 1'b1;
									end
									OPT_LEASE: begin
										if (!found_q[FLAG_LEASE]) begin
											lease_n             = shift_n;
											found_n[FLAG_LEASE] = 1'b1;
										end
									end
									default: begin
									end
								endcase
							end
						end
						left_n = left_q - 8'd1;
						if (left_q == 8'd1) begin
							phase_n = PH_CODE;
						end
					end
					default: begin
						phase_n = PH_CODE;
					end
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		emit                 = step && !done_q && (end_hit || last_byte);
		result.end_seen      = end_hit;
		result.found_flags   = found_n;
		result.lease_seconds = lease_n;
		result.message_type  = type_n;
		result.server_id     = server_n;
		result.dns_addr      = dns_n;
		result.gateway_addr  = router_n;
		result.subnet_mask   = mask_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CODE;
			code_q   <= 8'd0;
			left_q   <= 8'd0;
			cnt_q    <= 3'd0;
			shift_q  <= 32'd0;
			mask_q   <= 32'd0;
			router_q <= 32'd0;
			dns_q    <= 32'd0;
			server_q <= 32'd0;
			type_q   <= 8'd0;
			lease_q  <= 32'd0;
			found_q  <= 6'd0;
			done_q   <= 1'b0;
		end else begin
			done_q <= done_n;
			if (emit) begin
				phase_q  <= PH_CODE;
				code_q   <= 8'd0;
				left_q   <= 8'd0;
				cnt_q    <= 3'd0;
				shift_q  <= 32'd0;
				mask_q   <= 32'd0;
				router_q <= 32'd0;
				dns_q    <= 32'd0;
				server_q <= 32'd0;
				type_q   <= 8'd0;
				lease_q  <= 32'd0;
				found_q  <= 6'd0;
			end else begin
				phase_q  <= phase_n;
				code_q   <= code_n;
				left_q   <= left_n;
				cnt_q    <= cnt_n;
				shift_q  <= shift_n;
				mask_q   <= mask_n;
				router_q <= router_n;
				dns_q    <= dns_n;
				server_q <= server_n;
				type_q   <= type_n;
				lease_q  <= lease_n;
				found_q  <= found_n;
			end
		end
	end

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (found_q == 6'd0 && phase_q == PH_CODE))
		else $error("state not cleared after result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (found_q == 6'd0 && phase_q == PH_CODE))
		else $error("parse state live while skipping trailer");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("value count out of range");

	a_no_emit_in_trailer: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !emit)
		else $error("result during trailer skip");

endmodule

`default_nettype wire

// File: hdl/dhcp_option_parser_top.sv
// ---------------------------------------------------------------------------
// dhcp_option_parser_top
// DHCP options area parser with stream ports and a two-slot result buffer.
// ---------------------------------------------------------------------------
// Throughput: one input beat per cycle while the skid slot is empty.
// Result: registered into the output buffer when the beat holding the end option
//   or the last byte is accepted.
// A two-slot output buffer lets input keep flowing while a result waits;
//   input stalls only when both slots are full.
// Reset: asynchronous, clears parse state, stored values and output buffer valid flags.
`default_nettype none

module dhcp_option_parser_top
	import dop_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [7:0]             s_axis_tdata,  // [7:0] data_byte
	input  wire logic                   s_axis_tlast,  // last_byte
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [31:0] subnet_mask, [63:32] gateway_addr, [95:64] dns_addr,
	// [127:96] server_id, [135:128] message_type, [167:136] lease_seconds,
	// [173:168] found_flags, [175:174] zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                        m_axis_tuser   // end_seen
);

	logic    step;
	logic    emit;
	result_t result;
	result_t main_q, skid_q;
	logic    main_v_q, skid_v_q;
	logic    pop;

	assign s_axis_tready = ~skid_v_q;
	assign step          = s_axis_tvalid & s_axis_tready;
	assign pop           = main_v_q & m_axis_tready;

	dop_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.emit      (emit),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q || pop) begin
				if (skid_v_q) begin
					main_v_q <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					main_v_q <= emit;
				end
			end else if (emit) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (emit) begin
				main_q <= result;
			end
		end else if (emit) begin
			skid_q <= result;
		end
	end

	assign m_axis_tvalid = main_v_q;
	assign m_axis_tuser  = main_q.end_seen;
	assign m_axis_tdata  = {2'b00, main_q.found_flags, main_q.lease_seconds,
		main_q.message_type, main_q.server_id, main_q.dns_addr,
		main_q.gateway_addr, main_q.subnet_mask};

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid slot full with main slot empty");

	a_no_emit_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !emit)
		else $error("result produced with buffer full");

	a_held_until_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(main_v_q && !m_axis_tready) |=> main_v_q)
		else $error("result dropped before being taken");

endmodule

`default_nettype wire

// File: tb/dhcp_option_parser_top_test.sv
// ---------------------------------------------------------------------------
// dhcp_option_parser_top_test
// Streams DHCP options areas through the parser one byte beat at a time.
// A software copy of the parser predicts each result beat. Every result beat
// is checked field by field against the oldest prediction. Random gaps on
// the input and random back-pressure on the output hit every parse phase.
// ---------------------------------------------------------------------------
`default_nettype none

module dhcp_option_parser_top_test
	import dop_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BYTE_TARGET = 750;
	localparam int CYCLE_LIMIT = 400000;

	class dhcp_result_predictor;
		phase_t      phase;
		logic [7:0]  code;
		logic [7:0]  left;
		logic [2:0]  cnt;
		logic [31:0] shift;
		logic [31:0] mask;
		logic [31:0] router;
		logic [31:0] dns;
		logic [31:0] server;
		logic [7:0]  mtype;
		logic [31:0] lease;
		logic [5:0]  found;
		bit          skip_tail;
		result_t     expected_results[$];
		int          parsed_bytes;
		int          results_seen;
		int          mismatches;

		function new();
			restart_packet();
			skip_tail = 0;
			parsed_bytes = 0;
			results_seen = 0;
			mismatches = 0;
		endfunction

		function void restart_packet();
			phase = PH_CODE;
			code = '0;
			left = '0;
			cnt = '0;
			shift = '0;
			mask = '0;
			router = '0;
			dns = '0;
			server = '0;
			mtype = '0;
			lease = '0;
			found = '0;
		endfunction

		function void queue_result(bit end_flag);
			result_t r;
			r.subnet_mask = mask;
			r.gateway_addr = router;
			r.dns_addr = dns;
			r.server_id = server;
			r.message_type = mtype;
			r.lease_seconds = lease;
			r.found_flags = found;
			r.end_seen = end_flag;
			expected_results.push_back(r);
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			if (skip_tail) begin
				if (last)
					skip_tail = 0;
				return;
			end
			parsed_bytes++;
			case (phase)
				PH_CODE: begin
					if (b == OPT_END) begin
						queue_result(1'b1);
						restart_packet();
						skip_tail = !last;
						return;
					end
					if (b != OPT_PAD) begin
						code = b;
						phase = PH_LEN;
					end
				end
				PH_LEN: begin
					left = b;
					cnt = '0;
					shift = '0;
					phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
				end
				default: begin
					if (cnt < 3'd4) begin
						shift = {shift[23:0], b};
						cnt = cnt + 3'd1;
						if (cnt == 3'd1 && code == OPT_TYPE && !found[FLAG_TYPE]) begin
							mtype = b;
							found[FLAG_TYPE] = 1'b1;
						end
						if (cnt == 3'd4) begin
							case (code)
								OPT_MASK: begin
									mask = shift;
									found[FLAG_MASK] = 1'b1;
								end
								OPT_ROUTER: begin
									router = shift;
									found[FLAG_ROUTER] = 1'b1;
								end
								OPT_DNS: begin
									dns = shift;
									found[FLAG_DNS] = 1'b1;
								end
								OPT_SERVER: begin
									server = shift;
									found[FLAG_SERVER] = 1'b1;
								end
								OPT_LEASE: begin
									if (!found[FLAG_LEASE]) begin
										lease = shift;
										found[FLAG_LEASE] = 1'b1;
									end
								end
								default: ;
							endcase
						end
					end
					left = left - 8'd1;
					if (left == 8'd0)
						phase = PH_CODE;
				end
			endcase
			if (last) begin
				queue_result(1'b0);
				restart_packet();
			end
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
			result_t w;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result beat: expected none, actual %h/%b",
					$time, tdata, tuser);
				mismatches++;
				return;
			end
			w = expected_results.pop_front();
			results_seen++;
			check_field("subnet_mask", w.subnet_mask, tdata[31:0]);
			check_field("gateway_addr", w.gateway_addr, tdata[63:32]);
			check_field("dns_addr", w.dns_addr, tdata[95:64]);
			check_field("server_id", w.server_id, tdata[127:96]);
			check_field("message_type", 32'(w.message_type), 32'(tdata[135:128]));
			check_field("lease_seconds", w.lease_seconds, tdata[167:136]);
			check_field("found_flags", 32'(w.found_flags), 32'(tdata[173:168]));
			check_field("pad_bits", 32'd0, 32'(tdata[175:174]));
			check_field("end_seen", 32'(w.end_seen), 32'(tuser));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = 8'd0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	dhcp_result_predictor sb = new();
	logic [7:0] pkt[$];
	bit steady_run = 0;
	int packets_sent = 0;
	int hold_cnt = 0;
	int ready_roll;
	int cycles = 0;

	dhcp_option_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL dhcp_option_parser_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.take_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	// output back-pressure: mostly short holds, a few long ones
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			m_axis_tready <= 1'b0;
			hold_cnt--;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (!steady_run && ready_roll < 25) begin
				m_axis_tready <= 1'b0;
				hold_cnt = (ready_roll < 3) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (steady_run)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [7:0] value_byte();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] known_code(int idx);
		case (idx)
			0: return OPT_MASK;
			1: return OPT_ROUTER;
			2: return OPT_DNS;
			3: return OPT_LEASE;
			4: return OPT_TYPE;
			default: return OPT_SERVER;
		endcase
	endfunction

	task automatic send_packet();
		int gap;
		for (int i = 0; i < pkt.size(); i++) begin
			gap = pick_gap();
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= pkt[i];
			s_axis_tlast <= (i == pkt.size() - 1);
			@(posedge clk);
			while (!s_axis_tready) @(posedge clk);
		end
		packets_sent++;
	endtask

	task automatic build_packet();
		int kind;
		int sel;
		int len;
		int keep;
		logic [7:0] c;
		pkt.delete();
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(1, 5)) begin
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				pkt.push_back(OPT_PAD);
			end else begin
				if (sel <= 6) begin
					c = known_code(sel - 1);
					if ($urandom_range(0, 4) == 0)
						len = $urandom_range(0, 8);
					else
						len = (c == OPT_TYPE) ? 1 : 4;
				end else begin
					c = 8'($urandom_range(0, 255));
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) :
						$urandom_range(0, 6);
				end
				pkt.push_back(c);
				pkt.push_back(8'(len));
				repeat (len) pkt.push_back(value_byte());
			end
		end
		sel = $urandom_range(0, 9);
		if (sel < 9)
			pkt.push_back(OPT_END);
		if (sel == 7 || sel == 8)
			repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
		if (kind >= 7) begin
			keep = $urandom_range(1, pkt.size());
			while (pkt.size() > keep) void'(pkt.pop_back());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pad, full mask, message type, end on the last byte
		pkt = '{OPT_PAD, OPT_MASK, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'h00,
			OPT_TYPE, 8'd1, 8'h05, OPT_END};
		send_packet();
		// end before the last byte, trailing bytes dropped
		pkt = '{OPT_END, 8'h07, 8'hFF};
		send_packet();
		// short router, short lease, empty type, long dns
		pkt = '{OPT_ROUTER, 8'd2, 8'hAA, 8'hBB, OPT_LEASE, 8'd3, 8'd1, 8'd2, 8'd3,
			OPT_TYPE, 8'd0, OPT_DNS, 8'd6, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, OPT_END};
		send_packet();
		// server id done, then cut inside lease
		pkt = '{OPT_SERVER, 8'd4, 8'hC0, 8'hA8, 8'h01, 8'h01, OPT_LEASE, 8'd4, 8'h00};
		send_packet();
		// packet ends on a length byte
		pkt = '{OPT_MASK, 8'd4};
		send_packet();

		while (sb.parsed_bytes < BYTE_TARGET) begin
			build_packet();
			send_packet();
			if ($urandom_range(0, 4) == 0)
				steady_run = !steady_run;
		end
		s_axis_tvalid <= 1'b0;

		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d options areas, %0d parsed byte beats, %0d result beats checked",
			packets_sent, sb.parsed_bytes, sb.results_seen);
		$display("with random input gaps and output back-pressure; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("PASS dhcp_option_parser_top");
		end else begin
			$display("FAIL dhcp_option_parser_top");
		end
		$finish;
	end

endmodule

`default_nettype wire
